// ===== design/adsr_pkg.sv =====
// Shared types and constants of the ADSR envelope generator.
// Field widths, phase codes, point delay codes and register indexes.
// No dependencies; the interfaces and the envelope generator import this package.
package adsr_pkg;

	// Field widths of the item and result channels.
	localparam int ACTION_W = 1;
	localparam int INDEX_W  = 4;
	localparam int DELAY_W  = 16;
	localparam int ARG_W    = 16;
	localparam int LEVEL_W  = 16;
	localparam int PHASE_W  = 4;
	localparam int POINT_W  = DELAY_W + ARG_W;

	// Configuration port and register widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 23;
	localparam int SCALE_W     = 8;
	localparam int SUSTAIN_W   = 16;
	localparam int FADE_W      = 23;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_SCALE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FADE_OUT_STEP = 2'd2;

	// Item kinds.
	localparam logic [ACTION_W-1:0] ACT_TICK  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b1;

	// Special point delay codes.
	localparam logic signed [DELAY_W-1:0] DLY_DISABLE = 16'sd0;
	localparam logic signed [DELAY_W-1:0] DLY_HANG    = -16'sd1;
	localparam logic signed [DELAY_W-1:0] DLY_GOTO    = -16'sd2;
	localparam logic signed [DELAY_W-1:0] DLY_RESTART = -16'sd3;

	// Square of an argument, and the tick counter, as signed ramp length.
	localparam int SQ_W   = 31;
	localparam int TICK_W = 25;

	// Full scale squared: the target is arg*arg*2^F / (32767*32767).
	localparam logic [29:0] TARGET_DIV = 30'd1073676289;

	// Sustain hold length in ticks.
	localparam logic signed [TICK_W-1:0] SUSTAIN_TICKS = 25'sd128;

	// Output level: Q1.15, full scale is 1.0.
	localparam int                 LEVEL_Q_BITS = 15;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 16'd32768;

	// Envelope phases as reported on the result channel.
	typedef enum logic [PHASE_W-1:0] {
		PH_DISABLED  = 4'd0,
		PH_INITIAL   = 4'd1,
		PH_STARTLOOP = 4'd2,
		PH_LOOP      = 4'd3,
		PH_FADE      = 4'd4,
		PH_HANG      = 4'd5,
		PH_DECAY     = 4'd6,
		PH_RELEASE   = 4'd7,
		PH_SUSTAIN   = 4'd8
	} phase_t;

endpackage

// ===== design/adsr_in_if.sv =====
// Item channel of the envelope generator: valid/ready handshake plus payload.
// Depends on adsr_pkg for the field widths.
interface adsr_in_if;
	import adsr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic [INDEX_W-1:0]        point_index;
	logic signed [DELAY_W-1:0] point_delay;
	logic signed [ARG_W-1:0]   point_arg;
	logic                      start_req;
	logic                      hang_request;
	logic                      decay_request;
	logic                      release_request;

	modport source (
		output valid, action, point_index, point_delay, point_arg,
		output start_req, hang_request, decay_request, release_request,
		input  ready
	);

	modport sink (
		input  valid, action, point_index, point_delay, point_arg,
		input  start_req, hang_request, decay_request, release_request,
		output ready
	);

endinterface

// ===== design/adsr_out_if.sv =====
// Result channel of the envelope generator: valid/ready handshake plus payload.
// Depends on adsr_pkg for the field widths.
interface adsr_out_if;
	import adsr_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [PHASE_W-1:0] env_phase;
	logic               finished;

	modport source (
		output valid, level, env_phase, finished,
		input  ready
	);

	modport sink (
		input  valid, level, env_phase, finished,
		output ready
	);

endinterface

// ===== design/adsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module adsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/adsr_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Gives the quotient of unsigned operands; no dependencies.
module adsr_div #(
	parameter int WIDTH = 53
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] num,
	input  logic [WIDTH-1:0] den,
	output logic             done,
	output logic [WIDTH-1:0] quo
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   trial_sub;
	logic             fits;

	// Shift in the next numerator bit and try to subtract the divisor.
	assign trial     = {rem_q, quo_q[WIDTH-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = ~trial_sub[WIDTH];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Quotient and partial remainder shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/adsr_envelope_generator.sv =====
// Table-driven ADSR envelope generator. A write transaction stores one envelope point
// (delay, argument) in the point RAM; it gives no result. A tick transaction advances
// the envelope by one step and gives one result: the level in Q1.15 clamped to 0..1,
// the phase, and a finished flag. A tick that starts a new ramp waits for the bit-serial
// divider for the ramp step, which is DIV_W bits wide, the larger of LEVEL_FRAC_BITS+4
// and 24; the target level and the goto wrap use multiplications by constant
// reciprocals. Each goto in the table adds the S_GOTO and S_GWRAP states and a new read
// of the point RAM. Items are taken one at a time; a finished result waits in the output
// register while the next item is accepted, and a result that is still held stalls the
// following tick before it is reported. Points never written read as arbitrary data.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if, adsr_ram and adsr_div.
module adsr_envelope_generator #(
	parameter int ENV_POINTS      = 16,
	parameter int LEVEL_FRAC_BITS = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [adsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
	adsr_in_if.sink                           items,
	adsr_out_if.source                        results
);
	import adsr_pkg::*;

	localparam int F     = LEVEL_FRAC_BITS;
	localparam int LW    = F + 4;
	localparam int DW    = LW + 1;
	localparam int SUMW  = ((LW > FADE_W + 1) ? LW : FADE_W + 1) + 1;
	localparam int DIV_W = (LW > TICK_W - 1) ? LW : TICK_W - 1;
	localparam int AW    = $clog2(ENV_POINTS);
	localparam int HW    = $clog2(ENV_POINTS + 1);
	localparam int CW    = (HW > INDEX_W) ? HW : INDEX_W;
	localparam int OUT_SHIFT = F - LEVEL_Q_BITS;

	// Target estimate: quotient width, product widths and the reciprocal of full scale.
	localparam int QW     = F + 2;
	localparam int TPW    = SQ_W + QW;
	localparam int PW     = QW + 30;
	localparam logic [QW-1:0] TGT_M = QW'((longint'(1) << (F + SQ_W)) / longint'(TARGET_DIV));

	// Goto wrap: rounded-up reciprocal of the table size, exact for 16-bit destinations.
	localparam int GL     = $clog2(ENV_POINTS);
	localparam int GOTO_S = ARG_W + GL;
	localparam int GMW    = ARG_W + 1;
	localparam int GPW    = 2 * ARG_W + 1;
	localparam logic [GMW-1:0] GOTO_M = GMW'(((longint'(1) << GOTO_S) +
		longint'(ENV_POINTS) - longint'(1)) / longint'(ENV_POINTS));

	localparam longint LVL_ONE   = longint'(1) << F;
	localparam longint LVL_MAX   = (longint'(1) << (F + 3)) - longint'(1);
	localparam longint LVL_MIN   = -(longint'(1) << (F + 3));
	localparam longint NEAR_ZERO = (LVL_ONE + longint'(99999)) / longint'(100000);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_EVAL,
		S_GOTO,
		S_GWRAP,
		S_MUL,
		S_TGT,
		S_TFIX,
		S_DIFF,
		S_RSTART,
		S_RAMP,
		S_STEP,
		S_DEC1,
		S_DEC2,
		S_FINISH,
		S_EMIT
	} seq_state_t;

	// Saturate a wide signed value to the internal level range.
	function automatic logic signed [LW-1:0] sat_lvl(input logic signed [SUMW-1:0] v);
		if (v > SUMW'(LVL_MAX)) begin
			return LW'(LVL_MAX);
		end else if (v < SUMW'(LVL_MIN)) begin
			return LW'(LVL_MIN);
		end
		return v[LW-1:0];
	endfunction

	// Configuration registers.
	logic [SCALE_W-1:0]   scale_q;
	logic [SUSTAIN_W-1:0] sustain_q;
	logic [FADE_W-1:0]    fade_q;

	// Envelope state and sequencer.
	seq_state_t               state_q;
	phase_t                   phase_q;
	logic [AW-1:0]            ptr_q;
	logic signed [TICK_W-1:0] tick_q;
	logic signed [LW-1:0]     level_q;
	logic signed [LW-1:0]     ramp_q;
	logic                     hang_q;
	logic [HW-1:0]            hops_q;
	logic                     dec_req_q;
	logic                     rel_req_q;
	logic                     zero_out_q;

	// Working registers of a table step.
	logic signed [DELAY_W-1:0] delay_q;
	logic [SQ_W-1:0]           sq_q;
	logic signed [TICK_W-1:0]  t_q;
	logic signed [LW-1:0]      target_q;
	logic signed [DW-1:0]      diff_q;
	logic                      neg_q;
	logic [QW-1:0]             tq0_q;
	logic [PW-1:0]             tprod_q;
	logic [ARG_W-1:0]          ga_q;
	logic [ARG_W-1:0]          gq_q;

	// Output register.
	logic               res_valid_q;
	logic [LEVEL_W-1:0] res_level_q;
	phase_t             res_phase_q;
	logic               res_finished_q;

	// Point RAM ports.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [POINT_W-1:0]  ram_wdata;
	logic [POINT_W-1:0]  rd_data;
	logic signed [DELAY_W-1:0] rd_delay;
	logic signed [ARG_W-1:0]   rd_arg;
	logic signed [2*ARG_W-1:0] sq_full;
	logic                index_ok;

	// Divider ports.
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// Datapath helpers.
	logic                     goto_start;
	logic [AW-1:0]            ptr_next;
	logic signed [TICK_W-1:0] t_prod;
	logic signed [TICK_W-1:0] t_neg;
	logic [TICK_W-2:0]        t_mag;
	logic signed [DW-1:0]     diff_neg;
	logic [DW-2:0]            diff_mag;
	logic signed [SUMW-1:0]   ramp_mag_s;
	logic signed [SUMW-1:0]   fade_ext;
	logic signed [LW-1:0]     sus_level;
	logic signed [TICK_W-1:0] tick_dec;
	logic [LEVEL_W-1:0]       level_clamp;
	logic [TPW-1:0]           tq_prod;
	logic [QW-1:0]            tq1;
	logic [PW-1:0]            sq_shift;
	logic [GPW-1:0]           g_prod;
	logic [ARG_W-1:0]         g_back;
	logic [ARG_W-1:0]         g_rem;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_W'(1);
			sustain_q <= '0;
			fade_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UPDATE_SCALE:  scale_q   <= cfg_data[SCALE_W-1:0];
				CFG_SUSTAIN_LEVEL: sustain_q <= cfg_data[SUSTAIN_W-1:0];
				CFG_FADE_OUT_STEP: fade_q    <= cfg_data[FADE_W-1:0];
				default: ;
			endcase
		end
	end

	// Point writes go straight into the RAM on acceptance; slots beyond the table are dropped.
	assign index_ok  = CW'(items.point_index) < CW'(ENV_POINTS);
	assign ram_we    = items.valid && items.ready && (items.action == ACT_WRITE) && index_ok;
	assign ram_waddr = AW'(items.point_index);
	assign ram_wdata = {items.point_delay, items.point_arg};

	adsr_ram #(
		.WIDTH (POINT_W),
		.DEPTH (ENV_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	assign rd_delay = $signed(rd_data[POINT_W-1:ARG_W]);
	assign rd_arg   = $signed(rd_data[ARG_W-1:0]);
	assign sq_full  = rd_arg * rd_arg;

	// Operand helpers for the table step.
	assign goto_start = (rd_delay == DLY_GOTO) && (hops_q < HW'(ENV_POINTS));
	assign ptr_next   = (ptr_q == AW'(ENV_POINTS - 1)) ? '0 : ptr_q + 1'b1;
	assign t_prod     = delay_q * $signed({1'b0, scale_q});
	assign t_neg      = -t_q;
	assign t_mag      = t_q[TICK_W-1] ? t_neg[TICK_W-2:0] : t_q[TICK_W-2:0];
	assign diff_neg   = -diff_q;
	assign diff_mag   = diff_q[DW-1] ? diff_neg[DW-2:0] : diff_q[DW-2:0];
	assign ramp_mag_s = $signed(SUMW'(div_quo[DW-2:0]));
	assign fade_ext   = $signed(SUMW'(fade_q));
	assign sus_level  = $signed(LW'(sustain_q) << OUT_SHIFT);
	assign tick_dec   = tick_q - 1'b1;

	// Target level: the reciprocal estimate is low by at most one, a compare corrects it.
	assign tq_prod  = TPW'(sq_q) * TPW'(TGT_M);
	assign tq1      = tq0_q + 1'b1;
	assign sq_shift = PW'(sq_q) << F;

	// Goto destination modulo the table size: quotient by reciprocal, then the remainder.
	assign g_prod = GPW'(rd_data[ARG_W-1:0]) * GPW'(GOTO_M);
	assign g_back = gq_q * ARG_W'(ENV_POINTS);
	assign g_rem  = ga_q - g_back;

	// Divider operands: the ramp step is the only division by a variable.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_RSTART: begin
				div_start = 1'b1;
				div_num   = DIV_W'(diff_mag);
				div_den   = DIV_W'(t_mag);
			end
			default: ;
		endcase
	end

	adsr_div #(
		.WIDTH (DIV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Output level: clamp to 0..1 and truncate to Q1.15.
	always_comb begin
		if (level_q[LW-1]) begin
			level_clamp = '0;
		end else if (level_q > LW'(LVL_ONE)) begin
			level_clamp = LEVEL_FULL;
		end else begin
			level_clamp = level_q[F -: LEVEL_W];
		end
	end

	// Sequencer: one tick at a time, state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			phase_q        <= PH_DISABLED;
			ptr_q          <= '0;
			tick_q         <= '0;
			level_q        <= '0;
			ramp_q         <= '0;
			hang_q         <= 1'b0;
			hops_q         <= '0;
			dec_req_q      <= 1'b0;
			rel_req_q      <= 1'b0;
			zero_out_q     <= 1'b0;
			delay_q        <= '0;
			sq_q           <= '0;
			t_q            <= '0;
			target_q       <= '0;
			diff_q         <= '0;
			neg_q          <= 1'b0;
			tq0_q          <= '0;
			tprod_q        <= '0;
			ga_q           <= '0;
			gq_q           <= '0;
			res_valid_q    <= 1'b0;
			res_level_q    <= '0;
			res_phase_q    <= PH_DISABLED;
			res_finished_q <= 1'b0;
		end else begin
			if (results.ready && (state_q != S_EMIT)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (items.valid && (items.action == ACT_TICK)) begin
						dec_req_q <= items.decay_request;
						rel_req_q <= items.release_request;
						if (items.start_req) begin
							level_q <= '0;
							tick_q  <= '0;
							phase_q <= PH_INITIAL;
							hang_q  <= items.hang_request;
						end
						state_q <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					zero_out_q <= (phase_q == PH_DISABLED);
					unique case (phase_q) inside
						PH_DISABLED: begin
							state_q <= S_EMIT;
						end
						PH_INITIAL, PH_STARTLOOP: begin
							if ((phase_q == PH_INITIAL) && hang_q) begin
								phase_q <= PH_HANG;
								state_q <= S_FINISH;
							end else begin
								ptr_q   <= '0;
								hops_q  <= '0;
								state_q <= S_RD;
							end
						end
						PH_LOOP: begin
							hops_q  <= '0;
							state_q <= S_RD;
						end
						PH_FADE: begin
							state_q <= S_STEP;
						end
						PH_DECAY, PH_RELEASE: begin
							state_q <= S_DEC1;
						end
						PH_SUSTAIN: begin
							tick_q <= tick_dec;
							if (tick_q == TICK_W'(1)) begin
								phase_q <= PH_RELEASE;
							end
							state_q <= S_FINISH;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end

				// RAM read of the current point is in flight.
				S_RD: begin
					state_q <= S_EVAL;
				end

				S_EVAL: begin
					if (rd_delay == DLY_DISABLE) begin
						phase_q <= PH_DISABLED;
						state_q <= S_FINISH;
					end else if (rd_delay == DLY_HANG) begin
						phase_q <= PH_HANG;
						state_q <= S_FINISH;
					end else if (rd_delay == DLY_RESTART) begin
						phase_q <= PH_INITIAL;
						state_q <= S_FINISH;
					end else if (rd_delay == DLY_GOTO) begin
						if (goto_start) begin
							hops_q  <= hops_q + 1'b1;
							state_q <= S_GOTO;
						end else begin
							phase_q <= PH_DISABLED;
							state_q <= S_FINISH;
						end
					end else begin
						sq_q    <= sq_full[SQ_W-1:0];
						delay_q <= rd_delay;
						state_q <= S_MUL;
					end
				end

				// Goto destination wraps modulo the table size.
				S_GOTO: begin
					ga_q    <= rd_data[ARG_W-1:0];
					gq_q    <= ARG_W'(g_prod[GPW-1:GOTO_S]);
					state_q <= S_GWRAP;
				end

				S_GWRAP: begin
					ptr_q   <= g_rem[AW-1:0];
					state_q <= S_RD;
				end

				// Ramp length; a zero length counts as one tick.
				S_MUL: begin
					t_q     <= (t_prod == '0) ? TICK_W'(1) : t_prod;
					ptr_q   <= ptr_next;
					tq0_q   <= tq_prod[TPW-1:SQ_W];
					state_q <= S_TGT;
				end

				S_TGT: begin
					tprod_q <= PW'(tq1) * PW'(TARGET_DIV);
					state_q <= S_TFIX;
				end

				S_TFIX: begin
					target_q <= (tprod_q <= sq_shift) ? LW'(tq1) : LW'(tq0_q);
					state_q  <= S_DIFF;
				end

				S_DIFF: begin
					diff_q  <= DW'(target_q) - DW'(level_q);
					tick_q  <= t_q;
					state_q <= S_RSTART;
				end

				S_RSTART: begin
					neg_q   <= diff_q[DW-1] ^ t_q[TICK_W-1];
					state_q <= S_RAMP;
				end

				// Signed quotient truncated toward zero, then saturated.
				S_RAMP: begin
					if (div_done) begin
						ramp_q  <= sat_lvl(neg_q ? -ramp_mag_s : ramp_mag_s);
						phase_q <= PH_FADE;
						state_q <= S_STEP;
					end
				end

				S_STEP: begin
					level_q <= sat_lvl(SUMW'(level_q) + SUMW'(ramp_q));
					tick_q  <= tick_dec;
					if (tick_dec[TICK_W-1] || (tick_dec == '0)) begin
						phase_q <= PH_LOOP;
					end
					state_q <= S_FINISH;
				end

				S_DEC1: begin
					level_q <= sat_lvl(SUMW'(level_q) - fade_ext);
					state_q <= S_DEC2;
				end

				// Decay stops at sustain; release, or decay to silence, stops near zero.
				S_DEC2: begin
					if ((sustain_q != '0) && (phase_q == PH_DECAY)) begin
						if (level_q < sus_level) begin
							level_q <= sus_level;
							tick_q  <= SUSTAIN_TICKS;
							phase_q <= PH_SUSTAIN;
						end
					end else if (level_q < LW'(NEAR_ZERO)) begin
						level_q <= '0;
						phase_q <= PH_DISABLED;
					end
					state_q <= S_FINISH;
				end

				// Requests of this tick; release wins over decay.
				S_FINISH: begin
					if (rel_req_q) begin
						phase_q <= PH_RELEASE;
					end else if (dec_req_q) begin
						phase_q <= PH_DECAY;
					end
					state_q <= S_EMIT;
				end

				S_EMIT: begin
					if (!res_valid_q || results.ready) begin
						res_valid_q    <= 1'b1;
						res_level_q    <= zero_out_q ? '0 : level_clamp;
						res_phase_q    <= phase_q;
						res_finished_q <= (phase_q == PH_DISABLED);
						state_q        <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign items.ready       = (state_q == S_IDLE);
	assign results.valid     = res_valid_q;
	assign results.level     = res_level_q;
	assign results.env_phase = res_phase_q;
	assign results.finished  = res_finished_q;

	// A point write never produces a result transaction.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && (items.action == ACT_WRITE)) |=> !$rose(results.valid))
		else $error("result raised after a point write");

	// The finished flag agrees with the reported phase.
	a_finished_phase: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.finished == (results.env_phase == PH_DISABLED)))
		else $error("finished flag disagrees with phase");

	// Goto chains never exceed the table size within one tick.
	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hops_q <= HW'(ENV_POINTS))
		else $error("goto hop count beyond table size");

	// The divider only completes while the sequencer waits for it.
	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_RAMP))
		else $error("divider result arrived outside a wait state");

endmodule
